@@ rtl/rbfd_pkg.sv @@
`timescale 1ns / 1ps
package rbfd_pkg;
    localparam int PIX_W   = 32;
    localparam int DIM_W   = 9;
    localparam int COORD_W = 8;
    localparam int CH_W    = 8;
    // divider width: holds a channel sum over a full 256x256 window
    localparam int DIV_W   = 24;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_TGT_W = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [7:0]       col;
        logic [7:0]       row;
        logic [7:0]       red_in;
        logic [7:0]       green_in;
        logic [7:0]       blue_in;
        logic [7:0]       alpha_in;
    } req_t;

    typedef struct packed {
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic [7:0]       alpha_out;
        logic [8:0]       out_width;
        logic [8:0]       out_height;
        logic [1:0]       status;
    } rsp_t;

    // divider request/response between the window engine and the divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;
endpackage

@@ rtl/rbfd_if.sv @@
`timescale 1ns / 1ps
interface rbfd_req_if;
    import rbfd_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rbfd_rsp_if;
    import rbfd_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rbfd_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module rbfd_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  rbfd_pkg::div_req_t req,
    output rbfd_pkg::div_rsp_t rsp
);
    import rbfd_pkg::*;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 5'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DIV_W])
            begin
                rem_next = {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;
endmodule

@@ rtl/rgba_box_filter_downscaler.sv @@
`timescale 1ns / 1ps
// A read runs nine divider passes (output height, four window bounds, four
// means) plus one store read per source pixel in its window. A zero size
// answers without the divider, an out of range read after the height pass.
// One read at a time; writes every cycle while idle, also while a result waits.
// Reset: async active low; registers go to 256/256/64, frame store undefined.
module rgba_box_filter_downscaler
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    rbfd_req_if.sink    req,
    rbfd_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rbfd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
    localparam logic [8:0] MAXW9 = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
    localparam logic [8:0] MAXH9 = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_OH    = 13'b0000000000010,
        S_CHK   = 13'b0000000000100,
        S_X0    = 13'b0000000001000,
        S_X1    = 13'b0000000010000,
        S_Y0    = 13'b0000000100000,
        S_Y1    = 13'b0000001000000,
        S_ACC   = 13'b0000010000000,
        S_DRAIN = 13'b0000100000000,
        S_DIV   = 13'b0001000000000,
        S_DWAIT = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_WAITD = 13'b1000000000000
    } state_t;

    // configuration registers
    logic [8:0] src_w_reg, src_h_reg, tgt_w_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= 9'd256;
            src_h_reg <= 9'd256;
            tgt_w_reg <= 9'd64;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_SRC_W: src_w_reg <= pwdata[8:0];
                REG_SRC_H: src_h_reg <= pwdata[8:0];
                REG_TGT_W: tgt_w_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_SRC_W: prdata = {23'd0, src_w_reg};
            REG_SRC_H: prdata = {23'd0, src_h_reg};
            REG_TGT_W: prdata = {23'd0, tgt_w_reg};
            default:   prdata = '0;
        endcase
    end

    // saturated sizes
    logic [8:0] sw, sh, tw, ow_c;
    assign sw   = (src_w_reg > MAXW9) ? MAXW9 : src_w_reg;
    assign sh   = (src_h_reg > MAXH9) ? MAXH9 : src_h_reg;
    assign tw   = tgt_w_reg;
    assign ow_c = (tw < sw) ? tw : sw;

    // frame store
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    wr_addr, rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= {req.data.alpha_in, req.data.blue_in,
                             req.data.green_in, req.data.red_in};
        rd_data_reg <= mem[rd_addr];
    end

    // read engine state
    state_t           state_reg, state_next;
    logic [8:0]       ow_reg, oh_reg, col_reg, row_reg;
    logic [8:0]       x0_reg, x1_reg, y0_reg, x_reg, y_reg, y1_reg;
    logic [17:0]      cnt_reg;
    logic [DIV_W-1:0] sum_reg [4];
    logic [1:0]       ch_reg;
    logic [7:0]       mean_reg [4];
    logic [1:0]       status_reg;
    logic             rvalid_reg, acc_vld_reg;
    div_req_t         dreq;
    div_rsp_t         drsp;
    logic             req_fire;
    logic             out_load;
    logic             ok;
    rsp_t             rsp_c, out_reg;

    rbfd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign mem_we    = req_fire && req.data.req_type == REQ_WRITE
                       && {1'b0, req.data.col} < sw && {1'b0, req.data.row} < sh;
    assign wr_addr   = AW'(req.data.row) * ROW_STRIDE + AW'(req.data.col);
    assign rd_addr   = AW'(y_reg) * ROW_STRIDE + AW'(x_reg);
    // result moves to the output register once the previous one has left
    assign out_load  = (state_reg == S_OUT) && (!rvalid_reg || rsp.ready);

    logic [DIV_W-1:0] ceil_q;
    assign ceil_q = (drsp.rem != '0) ? drsp.quo + DIV_W'(1) : drsp.quo;

    // sequencer: height and bounds via shared divider, then walk window, then means; zero size or range exits early
    always_comb
    begin
        state_next = state_reg;
        dreq       = '0;
        unique case (state_reg)
            S_IDLE:
                if (req_fire && req.data.req_type == REQ_READ)
                    state_next = (sw == 9'd0 || sh == 9'd0 || tw == 9'd0) ? S_OUT : S_OH;
            S_OH:
            begin
                dreq.start = 1'b1;
                dreq.num   = DIV_W'(sh) * DIV_W'(ow_c);
                dreq.den   = DIV_W'(sw);
                state_next = S_WAITD;
            end
            S_WAITD:
                if (drsp.done)
                    state_next = S_CHK;
            S_CHK:
            begin
                if (col_reg >= ow_reg || row_reg >= oh_reg)
                    state_next = S_OUT;
                else
                begin
                    dreq.start = 1'b1;
                    dreq.num   = DIV_W'(col_reg) * DIV_W'(sw);
                    dreq.den   = DIV_W'(ow_reg);
                    state_next = S_X0;
                end
            end
            S_X0:
                if (drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = DIV_W'(col_reg + 9'd1) * DIV_W'(sw);
                    dreq.den   = DIV_W'(ow_reg);
                    state_next = S_X1;
                end
            S_X1:
                if (drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = DIV_W'(row_reg) * DIV_W'(sh);
                    dreq.den   = DIV_W'(oh_reg);
                    state_next = S_Y0;
                end
            S_Y0:
                if (drsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = DIV_W'(row_reg + 9'd1) * DIV_W'(sh);
                    dreq.den   = DIV_W'(oh_reg);
                    state_next = S_Y1;
                end
            S_Y1:
                if (drsp.done)
                    state_next = S_ACC;
            S_ACC:
                if (x_reg + 9'd1 >= x1_reg && y_reg + 9'd1 >= y1_reg)
                    state_next = S_DRAIN;
            S_DRAIN:
                if (!acc_vld_reg)
                    state_next = S_DIV;
            S_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num   = sum_reg[ch_reg];
                dreq.den   = DIV_W'(cnt_reg);
                state_next = S_DWAIT;
            end
            S_DWAIT:
                if (drsp.done)
                    state_next = (ch_reg == 2'd3) ? S_OUT : S_DIV;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rvalid_reg  <= 1'b0;
            acc_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_vld_reg <= (state_reg == S_ACC);
            if (out_load)
                rvalid_reg <= 1'b1;
            else if (rsp.ready)
                rvalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_fire)
        begin
            col_reg    <= {1'b0, req.data.col};
            row_reg    <= {1'b0, req.data.row};
            ow_reg     <= ow_c;
            status_reg <= ST_ZERO;
            ch_reg     <= 2'd0;
            cnt_reg    <= '0;
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i]  <= '0;
                mean_reg[i] <= '0;
            end
        end
        if (state_reg == S_WAITD && drsp.done)
            oh_reg <= (drsp.quo == '0) ? 9'd1 : drsp.quo[8:0];
        if (state_reg == S_CHK)
            status_reg <= (col_reg >= ow_reg || row_reg >= oh_reg) ? ST_RANGE : ST_OK;
        if (state_reg == S_X0 && drsp.done)
            x0_reg <= drsp.quo[8:0];
        if (state_reg == S_X1 && drsp.done)
            x1_reg <= (ceil_q > DIV_W'(sw)) ? sw : ceil_q[8:0];
        if (state_reg == S_Y0 && drsp.done)
            y0_reg <= drsp.quo[8:0];
        if (state_reg == S_Y1 && drsp.done)
        begin
            y1_reg <= (ceil_q > DIV_W'(sh)) ? sh : ceil_q[8:0];
            x_reg  <= x0_reg;
            y_reg  <= y0_reg;
        end
        if (state_reg == S_ACC)
        begin
            if (x_reg + 9'd1 >= x1_reg)
            begin
                x_reg <= x0_reg;
                y_reg <= y_reg + 9'd1;
            end
            else
                x_reg <= x_reg + 9'd1;
        end
        // accumulate each pixel from the registered store read of its address
        if (acc_vld_reg)
        begin
            cnt_reg <= cnt_reg + 18'd1;
            for (int i = 0; i < 4; i++)
                sum_reg[i] <= sum_reg[i] + DIV_W'(rd_data_reg[8*i +: 8]);
        end
        if (state_reg == S_DWAIT && drsp.done)
        begin
            mean_reg[ch_reg] <= drsp.quo[7:0];
            ch_reg           <= ch_reg + 2'd1;
        end
        if (out_load)
            out_reg <= rsp_c;
    end

    // result fields ahead of the output register
    assign ok = (status_reg == ST_OK);

    always_comb
    begin
        rsp_c.red_out    = mean_reg[0];
        rsp_c.green_out  = mean_reg[1];
        rsp_c.blue_out   = mean_reg[2];
        rsp_c.alpha_out  = mean_reg[3];
        rsp_c.out_width  = ok ? ow_reg : 9'd0;
        rsp_c.out_height = ok ? oh_reg : 9'd0;
        rsp_c.status     = status_reg;
    end

    assign rsp.valid = rvalid_reg;
    assign rsp.data  = out_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request taken while busy");
    a_hold_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.data))
        else $error("response dropped");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.data.status == ST_OK || rsp.data.status == ST_ZERO
                       || rsp.data.status == ST_RANGE))
        else $error("bad status");
`endif
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import rbfd_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam int SETTLE      = 50;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rbfd_req_if req ();
    rbfd_rsp_if rsp ();

    rgba_box_filter_downscaler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of registers and frame store
    logic [8:0]  src_w_reg;
    logic [8:0]  src_h_reg;
    logic [8:0]  tgt_w_reg;
    logic [31:0] pixel_mem [65536];

    rsp_t pixel_q [$];
    int   err_cnt;
    int   req_cnt;
    int   read_cnt;
    int   phase_cnt;
    bit   hold_rsp;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int eff_w();
        return (src_w_reg > 256) ? 256 : int'(src_w_reg);
    endfunction

    function automatic int eff_h();
        return (src_h_reg > 256) ? 256 : int'(src_h_reg);
    endfunction

    // output size in use; zero when any size is zero
    function automatic void out_dims(output int ow, output int oh);
        int sw;
        int sh;
        sw = eff_w();
        sh = eff_h();
        ow = 0;
        oh = 0;
        if (sw != 0 && sh != 0 && tgt_w_reg != 0)
        begin
            ow = (int'(tgt_w_reg) < sw) ? int'(tgt_w_reg) : sw;
            oh = (sh * ow) / sw;
            if (oh < 1) oh = 1;
        end
    endfunction

    // updates the shadow store on writes, averages the window on reads
    function automatic bit predict_pixel(input req_t r, output rsp_t res);
        int sw, sh, ow, oh, x0, x1, y0, y1, cnt;
        int unsigned sum [4];
        logic [31:0] px;
        sw = eff_w();
        sh = eff_h();
        res = '0;
        if (r.req_type == REQ_WRITE)
        begin
            if (r.col < sw && r.row < sh)
                pixel_mem[{r.row, r.col}] = {r.alpha_in, r.blue_in, r.green_in, r.red_in};
            return 1'b0;
        end
        out_dims(ow, oh);
        if (ow == 0)
        begin
            res.status = ST_ZERO;
            return 1'b1;
        end
        if (r.col >= ow || r.row >= oh)
        begin
            res.status = ST_RANGE;
            return 1'b1;
        end
        x0 = (r.col * sw) / ow;
        x1 = ((r.col + 1) * sw + ow - 1) / ow;
        if (x1 > sw) x1 = sw;
        y0 = (r.row * sh) / oh;
        y1 = ((r.row + 1) * sh + oh - 1) / oh;
        if (y1 > sh) y1 = sh;
        cnt = 0;
        for (int c = 0; c < 4; c++) sum[c] = 0;
        for (int y = y0; y < y1; y++)
        begin
            for (int x = x0; x < x1; x++)
            begin
                px = pixel_mem[y * 256 + x];
                for (int c = 0; c < 4; c++) sum[c] += px[8*c +: 8];
                cnt++;
            end
        end
        if (cnt != 0)
        begin
            res.red_out   = 8'(sum[0] / cnt);
            res.green_out = 8'(sum[1] / cnt);
            res.blue_out  = 8'(sum[2] / cnt);
            res.alpha_out = 8'(sum[3] / cnt);
        end
        res.out_width  = 9'(ow);
        res.out_height = 9'(oh);
        res.status     = ST_OK;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // send one request, record its prediction at acceptance
    task automatic send_req(input req_t r);
        rsp_t res;
        int   g;
        req.valid <= 1'b1;
        req.data  <= r;
        do @(posedge clk); while (!req.ready);
        req_cnt++;
        if (predict_pixel(r, res))
        begin
            pixel_q.push_back(res);
            read_cnt++;
        end
        g = rand_gap();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_write(input int c, input int r, input logic [31:0] px);
        req_t q;
        q = '0;
        q.req_type = REQ_WRITE;
        q.col      = 8'(c);
        q.row      = 8'(r);
        {q.alpha_in, q.blue_in, q.green_in, q.red_in} = px;
        send_req(q);
    endtask

    task automatic send_read(input int c, input int r);
        req_t q;
        q = '0;
        q.req_type = REQ_READ;
        q.col      = 8'(c);
        q.row      = 8'(r);
        {q.alpha_in, q.blue_in, q.green_in, q.red_in} = $urandom();
        send_req(q);
    endtask

    function automatic logic [31:0] rand_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // wait for the block to drain before touching registers
    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_W: src_w_reg = 9'(value);
            REG_SRC_H: src_h_reg = 9'(value);
            default:   tgt_w_reg = 9'(value);
        endcase
    endtask

    task automatic set_sizes(input int sw, input int sh, input int tw);
        wait_idle();
        apb_write(REG_SRC_W, sw);
        apb_write(REG_SRC_H, sh);
        apb_write(REG_TGT_W, tw);
        phase_cnt++;
    endtask

    // writes every source pixel so any later window is defined
    task automatic fill_image();
        for (int r = 0; r < eff_h(); r++)
            for (int c = 0; c < eff_w(); c++)
                send_write(c, r, rand_pixel());
    endtask

    task automatic read_all_outputs();
        int ow, oh;
        out_dims(ow, oh);
        for (int r = 0; r < oh; r++)
            for (int c = 0; c < ow; c++)
                send_read(c, r);
    endtask

    // defaults need no image: only out-of-range reads
    task automatic test_reset_defaults();
        send_read(200, 0);
        send_read(0, 255);
    endtask

    task automatic test_directed();
        set_sizes(4, 3, 2);
        fill_image();
        read_all_outputs();
        send_read(255, 0);
        send_read(0, 255);
        send_write(255, 255, 32'hFFFF_FFFF);
        send_write(4, 0, 32'h1234_5678);
        send_read(0, 0);
        // zero sizes
        set_sizes(4, 3, 0);
        send_read(0, 0);
        set_sizes(0, 3, 2);
        send_read(0, 0);
        set_sizes(4, 0, 2);
        send_read(0, 0);
        // height rounds down to zero, forced to one
        set_sizes(8, 1, 3);
        fill_image();
        read_all_outputs();
    endtask

    task automatic test_extremes();
        // oversized width saturates, target at max gives a copy
        set_sizes(511, 1, 256);
        fill_image();
        send_read(0, 0);
        send_read(255, 0);
        send_read(128, 0);
        send_read(0, 1);
        // whole wide source into one output pixel
        set_sizes(256, 2, 1);
        fill_image();
        send_read(0, 0);
        set_sizes(256, 2, 300);
        send_read(255, 1);
        // tall source, oversized height
        set_sizes(2, 400, 1);
        fill_image();
        send_read(0, 0);
        send_read(0, 127);
        send_read(0, 255);
    endtask

    // receiver held off while reads are sent; then results drain, more reads follow
    task automatic test_backpressure();
        set_sizes(4, 4, 2);
        fill_image();
        hold_rsp = 1'b1;
        repeat (12) send_read($urandom_range(0, 1), $urandom_range(0, 1));
        req.valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (8) send_read($urandom_range(0, 2), $urandom_range(0, 2));
    endtask

    task automatic test_random();
        int sw, sh, tw, ow, oh, n;
        for (int p = 0; p < 3; p++)
        begin
            sw = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 511) % 24
                                              : $urandom_range(1, 16);
            sh = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            tw = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 20);
            set_sizes(sw, sh, tw);
            fill_image();
            out_dims(ow, oh);
            n = 70;
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_read($urandom_range(0, 255), $urandom_range(0, 255));
                    else
                        send_read($urandom_range(0, ow), $urandom_range(0, oh));
                end
                else if ($urandom_range(0, 4) == 0)
                    send_write($urandom_range(0, 255), $urandom_range(0, 255), rand_pixel());
                else if (eff_w() > 0 && eff_h() > 0)
                    send_write($urandom_range(0, eff_w() - 1), $urandom_range(0, eff_h() - 1),
                               rand_pixel());
                else
                    send_write($urandom_range(0, 255), $urandom_range(0, 255), rand_pixel());
            end
        end
    endtask

    // response ready: random stretches, long hold on request
    initial
    begin
        int g;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                g = rand_gap();
                if (g > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = rsp.data;
            if (pixel_q.size() == 0)
            begin
                $display("ERROR @%0t: result with no pending read", $time);
                err_cnt++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (got.red_out !== want.red_out)
                    report_mismatch("red_out", got.red_out, want.red_out);
                if (got.green_out !== want.green_out)
                    report_mismatch("green_out", got.green_out, want.green_out);
                if (got.blue_out !== want.blue_out)
                    report_mismatch("blue_out", got.blue_out, want.blue_out);
                if (got.alpha_out !== want.alpha_out)
                    report_mismatch("alpha_out", got.alpha_out, want.alpha_out);
                if (got.out_width !== want.out_width)
                    report_mismatch("out_width", got.out_width, want.out_width);
                if (got.out_height !== want.out_height)
                    report_mismatch("out_height", got.out_height, want.out_height);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        int idle_cnt;
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", idle_cnt);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        err_cnt   = 0;
        req_cnt   = 0;
        read_cnt  = 0;
        phase_cnt = 0;
        hold_rsp  = 1'b0;
        src_w_reg = 9'd256;
        src_h_reg = 9'd256;
        tgt_w_reg = 9'd64;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_extremes();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (200) @(posedge clk);
        $display("Covered %0d requests (%0d reads) over %0d size settings,", req_cnt,
                 read_cnt, phase_cnt);
        $display("including zero sizes, range errors, saturation and output stalls.");
        if (err_cnt == 0 && pixel_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
